### rtl/core/cba_pkg.sv
package cba_pkg;

  localparam int CBA_XW    = 64;  // working width of the cylinder, head, sector and linear parts
  localparam int CBA_DVW   = 16;  // widest divisor (bytes per sector)
  localparam int CBA_NCELL = 64;  // one quotient bit per cell

  localparam logic [1:0] OP_NORM   = 2'd0;
  localparam logic [1:0] OP_TO_LIN = 2'd1;
  localparam logic [1:0] OP_TO_CHS = 2'd2;

  localparam logic [1:0] REG_HEADS   = 2'd0;
  localparam logic [1:0] REG_SECTORS = 2'd1;
  localparam logic [1:0] REG_BYTES   = 2'd2;

  localparam logic [7:0]  HEADS_RST   = 8'd2;
  localparam logic [7:0]  SECTORS_RST = 8'd18;
  localparam logic [15:0] BYTES_RST   = 16'd512;

  typedef struct packed {
    logic [1:0]         op;
    logic               one;
    logic [CBA_XW-1:0]  c;
    logic [CBA_XW-1:0]  h;
    logic [CBA_XW-1:0]  s;
    logic [31:0]        b;
    logic [CBA_XW-1:0]  lin;
    logic [CBA_XW-1:0]  dv;   // dividend magnitude, turns into the quotient
    logic [CBA_DVW-1:0] rem;
    logic               neg;
    logic [15:0]        br;
    logic [7:0]         sr;
    logic [7:0]         hr;
  } cba_rec_t;

  function automatic logic [CBA_XW-1:0] sx32(input logic [31:0] v);
    return {{(CBA_XW-32){v[31]}}, v};
  endfunction

endpackage

### rtl/core/cba_in_if.sv
interface cba_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic               one_based;
  logic signed [31:0] cyl_in;
  logic signed [31:0] head_in;
  logic signed [31:0] sector_in;
  logic signed [31:0] byte_in;
  logic signed [63:0] linear_in;

  modport source(output valid, op, one_based, cyl_in, head_in, sector_in, byte_in,
                 linear_in, input ready);
  modport sink(input valid, op, one_based, cyl_in, head_in, sector_in, byte_in,
               linear_in, output ready);
endinterface

### rtl/core/cba_out_if.sv
interface cba_out_if;
  logic               valid;
  logic               ready;
  logic [62:0]        cyl_out;
  logic [7:0]         head_out;
  logic [7:0]         sector_out;
  logic [15:0]        byte_out;
  logic signed [63:0] linear_out;

  modport source(output valid, cyl_out, head_out, sector_out, byte_out, linear_out,
                 input ready);
  modport sink(input valid, cyl_out, head_out, sector_out, byte_out, linear_out,
               output ready);
endinterface

### rtl/core/cba_div_cell.sv
module cba_div_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          v_i,
  input  cba_pkg::cba_rec_t             rec_i,
  input  logic [cba_pkg::CBA_DVW-1:0]   dvs,
  output logic                          v_o,
  output cba_pkg::cba_rec_t             rec_o
);
  import cba_pkg::*;

  logic [CBA_DVW:0] part;
  logic             fits;
  cba_rec_t         rec_nxt;
  cba_rec_t         rec_r;
  logic             v_r;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    part    = {rec_i.rem, rec_i.dv[CBA_XW-1]};
    fits    = (part >= {1'b0, dvs});
    rec_nxt = rec_i;
    rec_nxt.dv  = {rec_i.dv[CBA_XW-2:0], fits};
    rec_nxt.rem = fits ? CBA_DVW'(part - {1'b0, dvs}) : part[CBA_DVW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rec_r <= rec_nxt;
    end
  end

  assign v_o   = v_r;
  assign rec_o = rec_r;
endmodule

### rtl/core/cba_div_chain.sv
module cba_div_chain (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          v_i,
  input  cba_pkg::cba_rec_t             rec_i,
  input  logic [cba_pkg::CBA_DVW-1:0]   dvs,
  output logic                          v_o,
  output cba_pkg::cba_rec_t             rec_o
);
  import cba_pkg::*;

  logic     v_w   [CBA_NCELL+1];
  cba_rec_t rec_w [CBA_NCELL+1];

  assign v_w[0]   = v_i;
  assign rec_w[0] = rec_i;

  for (genvar i = 0; i < CBA_NCELL; i++) begin : g_cell
    cba_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .v_i   (v_w[i]),
      .rec_i (rec_w[i]),
      .dvs   (dvs),
      .v_o   (v_w[i+1]),
      .rec_o (rec_w[i+1])
    );
  end

  assign v_o   = v_w[CBA_NCELL];
  assign rec_o = rec_w[CBA_NCELL];
endmodule

### rtl/core/chs_byte_address_converter.sv
// Throughput: one item per cycle; three 64-cell divider chains (one quotient
// bit per cell) plus eight wide arithmetic stages form one pipeline.
// The whole pipeline holds while a result waits on the out channel.
// Reset (rst_n low, synchronous): pipeline empties, geometry returns to
// 2 heads, 18 sectors per track, 512 bytes per sector.
module chs_byte_address_converter (
  input  logic        clk,
  input  logic        rst_n,
  cba_in_if.sink      in_ch,
  cba_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_data
);
  import cba_pkg::*;

  // geometry registers
  logic [7:0]  heads_r;
  logic [7:0]  sects_r;
  logic [15:0] bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heads_r <= HEADS_RST;
      sects_r <= SECTORS_RST;
      bytes_r <= BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_HEADS:   heads_r <= cfg_data[7:0];
        REG_SECTORS: sects_r <= cfg_data[7:0];
        REG_BYTES:   bytes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // a zero geometry register acts as one
  logic [7:0]         hn, sn;
  logic [15:0]        bn;
  logic [CBA_DVW-1:0] hd, sd, bd;
  assign hn = (heads_r == 8'd0) ? 8'd1 : heads_r;
  assign sn = (sects_r == 8'd0) ? 8'd1 : sects_r;
  assign bn = (bytes_r == 16'd0) ? 16'd1 : bytes_r;
  assign hd = CBA_DVW'(hn);
  assign sd = CBA_DVW'(sn);
  assign bd = CBA_DVW'(bn);

  // global advance: move everything while the output register can take an item
  logic adv;
  logic out_v_r;
  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 0: load address parts, first linear product, byte dividend magnitude
  cba_rec_t s0_nxt, s0_r;
  logic     s0_v_r;
  logic [CBA_XW-1:0] bv;
  always_comb begin
    s0_nxt     = '0;
    s0_nxt.op  = in_ch.op;
    s0_nxt.one = in_ch.one_based;
    s0_nxt.b   = in_ch.byte_in;
    if (in_ch.op == OP_TO_CHS) begin
      s0_nxt.c = '0;
      s0_nxt.h = '0;
      s0_nxt.s = CBA_XW'(in_ch.one_based);
      bv       = in_ch.linear_in;
    end else begin
      s0_nxt.c = sx32(in_ch.cyl_in);
      s0_nxt.h = sx32(in_ch.head_in);
      s0_nxt.s = sx32(in_ch.sector_in);
      bv       = sx32(in_ch.byte_in);
    end
    s0_nxt.lin = sx32(in_ch.cyl_in) * CBA_XW'(hn) + sx32(in_ch.head_in);
    s0_nxt.neg = bv[CBA_XW-1];
    s0_nxt.dv  = bv[CBA_XW-1] ? -bv : bv;
  end

  // stage 1: times sectors, plus sector, minus base
  cba_rec_t s1_nxt, s1_r;
  logic     s1_v_r;
  always_comb begin
    s1_nxt     = s0_r;
    s1_nxt.lin = s0_r.lin * CBA_XW'(sn) + s0_r.s - CBA_XW'(s0_r.one);
  end

  // stage 2: times bytes, plus byte
  cba_rec_t s2_nxt, s2_r;
  logic     s2_v_r;
  always_comb begin
    s2_nxt     = s1_r;
    s2_nxt.lin = s1_r.lin * CBA_XW'(bn) + sx32(s1_r.b);
  end

  // byte carry into sector
  logic     c1_v;
  cba_rec_t c1_rec;
  cba_div_chain u_div_byte (
    .clk(clk), .rst_n(rst_n), .adv(adv), .v_i(s2_v_r), .rec_i(s2_r), .dvs(bd),
    .v_o(c1_v), .rec_o(c1_rec)
  );

  // fold byte quotient into sector, drop the base; clamp negative byte remainder
  cba_rec_t f1_nxt, f1_r;
  logic     f1_v_r;
  always_comb begin
    f1_nxt    = c1_rec;
    f1_nxt.s  = (c1_rec.neg ? c1_rec.s - c1_rec.dv : c1_rec.s + c1_rec.dv)
                - CBA_XW'(c1_rec.one);
    f1_nxt.br = c1_rec.neg ? 16'd0 : 16'(c1_rec.rem);
  end

  // sector dividend magnitude
  cba_rec_t g1_nxt, g1_r;
  logic     g1_v_r;
  always_comb begin
    g1_nxt     = f1_r;
    g1_nxt.neg = f1_r.s[CBA_XW-1];
    g1_nxt.dv  = f1_r.s[CBA_XW-1] ? -f1_r.s : f1_r.s;
    g1_nxt.rem = '0;
  end

  // sector carry into head
  logic     c2_v;
  cba_rec_t c2_rec;
  cba_div_chain u_div_sect (
    .clk(clk), .rst_n(rst_n), .adv(adv), .v_i(g1_v_r), .rec_i(g1_r), .dvs(sd),
    .v_o(c2_v), .rec_o(c2_rec)
  );

  cba_rec_t f2_nxt, f2_r;
  logic     f2_v_r;
  always_comb begin
    f2_nxt    = c2_rec;
    f2_nxt.h  = c2_rec.neg ? c2_rec.h - c2_rec.dv : c2_rec.h + c2_rec.dv;
    f2_nxt.sr = (c2_rec.neg ? 8'd0 : c2_rec.rem[7:0]) + 8'(c2_rec.one);
  end

  cba_rec_t g2_nxt, g2_r;
  logic     g2_v_r;
  always_comb begin
    g2_nxt     = f2_r;
    g2_nxt.neg = f2_r.h[CBA_XW-1];
    g2_nxt.dv  = f2_r.h[CBA_XW-1] ? -f2_r.h : f2_r.h;
    g2_nxt.rem = '0;
  end

  // head carry into cylinder
  logic     c3_v;
  cba_rec_t c3_rec;
  cba_div_chain u_div_head (
    .clk(clk), .rst_n(rst_n), .adv(adv), .v_i(g2_v_r), .rec_i(g2_r), .dvs(hd),
    .v_o(c3_v), .rec_o(c3_rec)
  );

  cba_rec_t f3_nxt, f3_r;
  logic     f3_v_r;
  always_comb begin
    f3_nxt    = c3_rec;
    f3_nxt.c  = c3_rec.neg ? c3_rec.c - c3_rec.dv : c3_rec.c + c3_rec.dv;
    f3_nxt.hr = c3_rec.neg ? 8'd0 : c3_rec.rem[7:0];
  end

  // valid bits of the local stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      f1_v_r <= 1'b0;
      g1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      g2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_ch.valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      f1_v_r <= c1_v;
      g1_v_r <= f1_v_r;
      f2_v_r <= c2_v;
      g2_v_r <= f2_v_r;
      f3_v_r <= c3_v;
      out_v_r <= f3_v_r;
    end
  end

  // result selection per operation; unused fields read zero
  logic [62:0]       cyl_nxt;
  logic [7:0]        head_nxt, sect_nxt;
  logic [15:0]       byte_nxt;
  logic [CBA_XW-1:0] lin_nxt;
  always_comb begin
    cyl_nxt  = '0;
    head_nxt = '0;
    sect_nxt = '0;
    byte_nxt = '0;
    lin_nxt  = '0;
    case (f3_r.op)
      OP_NORM, OP_TO_CHS: begin
        cyl_nxt  = f3_r.c[CBA_XW-1] ? 63'd0 : f3_r.c[62:0];
        head_nxt = f3_r.hr;
        sect_nxt = f3_r.sr;
        byte_nxt = f3_r.br;
      end
      OP_TO_LIN: begin
        lin_nxt = f3_r.lin;
      end
      default: ;
    endcase
  end

  logic [62:0]       cyl_r;
  logic [7:0]        head_r, sect_r;
  logic [15:0]       byte_r;
  logic [CBA_XW-1:0] lin_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r   <= s0_nxt;
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      f1_r   <= f1_nxt;
      g1_r   <= g1_nxt;
      f2_r   <= f2_nxt;
      g2_r   <= g2_nxt;
      f3_r   <= f3_nxt;
      cyl_r  <= cyl_nxt;
      head_r <= head_nxt;
      sect_r <= sect_nxt;
      byte_r <= byte_nxt;
      lin_r  <= lin_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.cyl_out    = cyl_r;
  assign out_ch.head_out   = head_r;
  assign out_ch.sector_out = sect_r;
  assign out_ch.byte_out   = byte_r;
  assign out_ch.linear_out = lin_r;
endmodule

### rtl/core/cba_chk.sv
module cba_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [62:0] out_cyl,
  input logic [7:0]  out_head,
  input logic [7:0]  out_sector,
  input logic [15:0] out_byte,
  input logic [63:0] out_linear
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with empty output register");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cyl) && $stable(out_linear))
    else $error("stalled result changed");

  a_lin_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_linear != 64'd0 |->
      out_cyl == 63'd0 && out_head == 8'd0 && out_sector == 8'd0 && out_byte == 16'd0)
    else $error("linear result mixed with address fields");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_head != 8'hFF && out_byte != 16'hFFFF)
    else $error("remainder out of range");

endmodule

bind chs_byte_address_converter cba_chk u_cba_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_cyl    (out_ch.cyl_out),
  .out_head   (out_ch.head_out),
  .out_sector (out_ch.sector_out),
  .out_byte   (out_ch.byte_out),
  .out_linear (out_ch.linear_out)
);
